### sv/dvc_pkg.sv
`default_nettype none
package dvc_pkg;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Mode register codes
	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_BELOW = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// Job handed from front to back.
	// enc = 1: data holds the difference, len + 1 bytes go out.
	// enc = 0: one word goes out with data as decoded_value.
	typedef struct packed {
		logic        enc;
		logic [2:0]  len;
		logic [63:0] data;
		logic        vv;
		logic [1:0]  status;
	} job_t;

endpackage
`default_nettype wire

### sv/dvc_front.sv
`default_nettype none
module dvc_front import dvc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        mode,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] value,
	input  wire logic [7:0]  in_byte,
	input  wire logic        q_full,
	output logic             push,
	output job_t             push_job
);

	logic [63:0] last_q;
	logic [63:0] sum_q;
	logic [60:0] partial_q;
	logic [2:0]  left_q;

	logic [63:0] diff;
	logic        below;
	logic        too_large;
	logic [2:0]  enc_len;

	logic [60:0] partial_n;
	logic [2:0]  left_n;
	logic        done;
	logic [63:0] sum_n;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// Encode side: difference, range checks, code length
	assign diff      = value - last_q;
	assign below     = value < last_q;
	assign too_large = |diff[63:61];

	always_comb begin
		enc_len = 3'd0;
		for (int m = 1; m < 8; m++) begin
			if ((diff >> (8 * m - 3)) != 64'd0) begin
				enc_len = 3'(m);
			end
		end
	end

	// Decode side: byte assembly and running sum
	always_comb begin
		if (left_q == 3'd0) begin
			partial_n = {56'd0, in_byte[4:0]};
			left_n    = in_byte[7:5];
		end else begin
			partial_n = {partial_q[52:0], in_byte};
			left_n    = left_q - 3'd1;
		end
		done  = left_n == 3'd0;
		sum_n = sum_q + {3'd0, partial_n};
	end

	// Job for the back end
	always_comb begin
		push_job = '0;
		if (mode == MODE_ENC) begin
			if (below) begin
				push_job.status = ST_BELOW;
			end else if (too_large) begin
				push_job.status = ST_RANGE;
			end else begin
				push_job.enc  = 1'b1;
				push_job.len  = enc_len;
				push_job.data = diff;
			end
		end else if (done) begin
			push_job.data = sum_n;
			push_job.vv   = 1'b1;
		end
	end

	// State update on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= '0;
			sum_q     <= '0;
			partial_q <= '0;
			left_q    <= '0;
		end else if (push) begin
			if (mode == MODE_ENC) begin
				if (!below && !too_large) begin
					last_q <= value;
				end
			end else begin
				left_q <= left_n;
				if (done) begin
					sum_q     <= sum_n;
					partial_q <= '0;
				end else begin
					partial_q <= partial_n;
				end
			end
		end
	end

endmodule
`default_nettype wire

### sv/dvc_queue.sv
`default_nettype none
module dvc_queue import dvc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output logic      full,
	output logic      head_valid,
	output job_t      head
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full       = cnt_q == CW'(DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### sv/dvc_back.sv
`default_nettype none
module dvc_back import dvc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        head_valid,
	input  wire job_t        head,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             out_last,
	output logic [63:0]      decoded_value,
	output logic             value_valid,
	output logic [1:0]       status
);

	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [63:0] dv_q;
	logic        vv_q;
	logic [1:0]  st_q;
	logic [2:0]  idx_q;

	logic        load;
	logic        job_last;
	logic [2:0]  k;
	logic [7:0]  sel;
	logic [7:0]  byte_n;

	// Output register takes a word when empty or being drained
	assign load     = head_valid && (!out_valid_q || out_ready);
	assign job_last = !head.enc || (idx_q == head.len);
	assign pop      = load && job_last;

	// Big-endian byte select; first byte carries the length tag
	assign k   = head.len - idx_q;
	assign sel = 8'(head.data >> {k, 3'b000});

	always_comb begin
		if (!head.enc) begin
			byte_n = 8'd0;
		end else if (idx_q == 3'd0) begin
			byte_n = {head.len, sel[4:0]};
		end else begin
			byte_n = sel;
		end
	end

	// Byte index within the current job and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= job_last ? 3'd0 : idx_q + 3'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= byte_n;
			last_q <= job_last;
			dv_q   <= head.enc ? 64'd0 : head.data;
			vv_q   <= head.vv;
			st_q   <= head.status;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = byte_q;
	assign out_last      = last_q;
	assign decoded_value = dv_q;
	assign value_valid   = vv_q;
	assign status        = st_q;

endmodule
`default_nettype wire

### sv/delta_varint_codec.sv
// An accepted word is queued as a job, then loaded into the output register.
// Throughput in decode mode: one byte per cycle when not stalled, one result word each.
// Encode mode: a value gives 1 to 8 code bytes, sent by the byte serializer.
// A two-entry job queue lets the input keep flowing while the serializer drains.
// Reset (arst_n low, asynchronous): mode encode, all sums, last value and queue cleared.
`default_nettype none
module delta_varint_codec import dvc_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_mode,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] value,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             out_last,
	output logic [63:0]      decoded_value,
	output logic             value_valid,
	output logic [1:0]       status
);

	logic mode_q;
	logic q_full;
	logic push;
	logic pop;
	logic head_valid;
	job_t push_job;
	job_t head;

	// Mode register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENC;
		end else if (cfg_valid) begin
			mode_q <= cfg_mode;
		end
	end

	dvc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (mode_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.value    (value),
		.in_byte  (in_byte),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	dvc_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	dvc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.out_last      (out_last),
		.decoded_value (decoded_value),
		.value_valid   (value_valid),
		.status        (status)
	);

endmodule
`default_nettype wire

### sv/dvc_checker.sv
`default_nettype none
module dvc_checker import dvc_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  out_byte,
	input wire logic        out_last,
	input wire logic [63:0] decoded_value,
	input wire logic        value_valid,
	input wire logic [1:0]  status
);

	// Stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last)
			&& $stable(decoded_value) && $stable(value_valid) && $stable(status))
		else $error("result word changed while stalled");

	// A decoded value is a single clean word
	a_vv_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && value_valid |-> status == ST_OK && out_byte == 8'd0 && out_last)
		else $error("decoded value word malformed");

	// Error words carry nothing else
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> out_last && !value_valid && out_byte == 8'd0
			&& decoded_value == 64'd0)
		else $error("error word malformed");

	// Without a completed value the value field is zero
	a_dv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !value_valid |-> decoded_value == 64'd0)
		else $error("stray decoded value");

endmodule

bind delta_varint_codec dvc_checker u_dvc_checker (.*);
`default_nettype wire
